// ----- src/tsrs_pkg.sv -----
// ============================================================================
// tsrs_pkg
// Shared field widths, action codes and status codes of the totient
// square range-sum core.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package tsrs_pkg;

    // Fixed field widths
    localparam int RANGE_W  = 17;
    localparam int SUM_W    = 64;
    localparam int STATUS_W = 2;

    // Action codes
    localparam logic ACT_BUILD = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd2;

endpackage

`default_nettype wire

// ----- src/tsrs_builder.sv -----
// ============================================================================
// tsrs_builder
// Table builder: runs the totient sieve over a local phi memory, then
// streams prefix sums of phi squared out on a write port.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tsrs_builder #(
    parameter int MAX_N = 65536
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                go,
    output logic                                     fin,
    output logic                                     pf_we,
    output logic [$clog2(MAX_N + 1)-1:0]             pf_waddr,
    output logic [tsrs_pkg::SUM_W-1:0]               pf_wdata
);

    localparam int IDX_W      = $clog2(MAX_N + 1);
    localparam int CNT_W      = IDX_W + 1;
    localparam int PHI_W      = IDX_W;
    // Newton steps for the inverse mod 2^PHI_W: x0 = p is good to 3 bits
    localparam int NEWT_RAW   = $clog2((PHI_W + 2) / 3);
    localparam int NEWT_ITERS = (NEWT_RAW < 1) ? 1 : NEWT_RAW;
    localparam int IT_W       = $clog2(NEWT_ITERS + 1);
    localparam logic [CNT_W-1:0] LAST    = CNT_W'(MAX_N);
    localparam logic [IT_W-1:0]  IT_LAST = IT_W'(NEWT_ITERS - 1);

    typedef enum logic [11:0] {
        B_IDLE   = 12'b0000_0000_0001,
        B_INIT   = 12'b0000_0000_0010,
        B_CHK_RD = 12'b0000_0000_0100,
        B_CHK    = 12'b0000_0000_1000,
        B_INV_A  = 12'b0000_0001_0000,
        B_INV_B  = 12'b0000_0010_0000,
        B_SV_RD  = 12'b0000_0100_0000,
        B_SV_MUL = 12'b0000_1000_0000,
        B_SV_WR  = 12'b0001_0000_0000,
        B_PF_RD  = 12'b0010_0000_0000,
        B_PF_SQ  = 12'b0100_0000_0000,
        B_PF_WR  = 12'b1000_0000_0000
    } bstate_t;

    // Phi memory
    logic [PHI_W-1:0] phi_mem [0:MAX_N];
    logic [PHI_W-1:0] phi_rd_reg;
    logic             phi_we;
    logic [IDX_W-1:0] phi_waddr;
    logic [PHI_W-1:0] phi_wdata;
    logic [IDX_W-1:0] phi_raddr;

    // Control registers
    bstate_t          state_reg, state_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [IT_W-1:0]  it_reg, it_next;
    logic             fin_reg, fin_next;

    // Datapath registers
    logic [PHI_W-1:0] p_reg, p_next;
    logic             p_even_reg, p_even_next;
    logic [PHI_W-1:0] inv_reg, inv_next;
    logic [PHI_W-1:0] t_reg, t_next;
    logic [PHI_W-1:0] hold_reg, hold_next;
    logic [PHI_W-1:0] q_reg, q_next;
    logic [tsrs_pkg::SUM_W-1:0] sq_reg, sq_next;
    logic [tsrs_pkg::SUM_W-1:0] acc_reg, acc_next;

    // Shared multiplier
    logic [PHI_W-1:0]   mul_x, mul_y;
    logic [2*PHI_W-1:0] mul_p;
    logic [CNT_W-1:0]   j_sum;
    logic [tsrs_pkg::SUM_W-1:0] acc_sum;

    assign mul_p   = mul_x * mul_y;
    assign j_sum   = j_reg + CNT_W'(p_reg);
    assign acc_sum = acc_reg + sq_reg;

    // Multiplier operand select
    always_comb
    begin
        mul_x = phi_rd_reg;
        mul_y = inv_reg;
        case (state_reg)
            B_INV_A:
            begin
                mul_x = p_reg;
                mul_y = inv_reg;
            end
            B_INV_B:
            begin
                mul_x = inv_reg;
                mul_y = PHI_W'(2) - t_reg;
            end
            B_PF_SQ:
            begin
                mul_x = phi_rd_reg;
                mul_y = phi_rd_reg;
            end
            default:
            begin
                mul_x = phi_rd_reg;
                mul_y = inv_reg;
            end
        endcase
    end

    // Phi memory ports
    always_comb
    begin
        phi_we    = 1'b0;
        phi_waddr = i_reg[IDX_W-1:0];
        phi_wdata = i_reg[PHI_W-1:0];
        phi_raddr = i_reg[IDX_W-1:0];
        case (state_reg)
            B_INIT:
            begin
                phi_we = 1'b1;
            end
            B_SV_RD:
            begin
                phi_raddr = j_reg[IDX_W-1:0];
            end
            B_SV_WR:
            begin
                phi_we    = 1'b1;
                phi_waddr = j_reg[IDX_W-1:0];
                phi_wdata = hold_reg - q_reg;
            end
            default:
            begin
                phi_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (phi_we)
        begin
            phi_mem[phi_waddr] <= phi_wdata;
        end
        phi_rd_reg <= phi_mem[phi_raddr];
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        it_next     = it_reg;
        fin_next    = 1'b0;
        p_next      = p_reg;
        p_even_next = p_even_reg;
        inv_next    = inv_reg;
        t_next      = t_reg;
        hold_next   = hold_reg;
        q_next      = q_reg;
        sq_next     = sq_reg;
        acc_next    = acc_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (go)
                begin
                    i_next     = '0;
                    state_next = B_INIT;
                end
            end
            // phi[i] = i for the whole table
            B_INIT:
            begin
                if (i_reg == LAST)
                begin
                    i_next     = CNT_W'(2);
                    state_next = B_CHK_RD;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            B_CHK_RD:
            begin
                state_next = B_CHK;
            end
            // Untouched entry means i is prime
            B_CHK:
            begin
                if (phi_rd_reg == i_reg[PHI_W-1:0])
                begin
                    p_next      = i_reg[PHI_W-1:0];
                    p_even_next = ~i_reg[0];
                    inv_next    = i_reg[PHI_W-1:0];
                    it_next     = '0;
                    j_next      = i_reg;
                    state_next  = i_reg[0] ? B_INV_A : B_SV_RD;
                end
                else if (i_reg == LAST)
                begin
                    i_next     = '0;
                    acc_next   = '0;
                    state_next = B_PF_RD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = B_CHK_RD;
                end
            end
            // Newton step for p^-1 mod 2^PHI_W, first half: t = p * x
            B_INV_A:
            begin
                t_next     = mul_p[PHI_W-1:0];
                state_next = B_INV_B;
            end
            // Second half: x = x * (2 - t)
            B_INV_B:
            begin
                inv_next = mul_p[PHI_W-1:0];
                it_next  = it_reg + 1'b1;
                if (it_reg == IT_LAST)
                begin
                    state_next = B_SV_RD;
                end
                else
                begin
                    state_next = B_INV_A;
                end
            end
            B_SV_RD:
            begin
                state_next = B_SV_MUL;
            end
            // phi[j] is a multiple of p here, so the quotient is exact
            B_SV_MUL:
            begin
                hold_next  = phi_rd_reg;
                q_next     = p_even_reg ? (phi_rd_reg >> 1) : mul_p[PHI_W-1:0];
                state_next = B_SV_WR;
            end
            B_SV_WR:
            begin
                if (j_sum > LAST)
                begin
                    if (i_reg == LAST)
                    begin
                        i_next     = '0;
                        acc_next   = '0;
                        state_next = B_PF_RD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = B_CHK_RD;
                    end
                end
                else
                begin
                    j_next     = j_sum;
                    state_next = B_SV_RD;
                end
            end
            B_PF_RD:
            begin
                state_next = B_PF_SQ;
            end
            // Entries 0 and 1 contribute nothing
            B_PF_SQ:
            begin
                if (i_reg < CNT_W'(2))
                begin
                    sq_next = '0;
                end
                else
                begin
                    sq_next = tsrs_pkg::SUM_W'(mul_p);
                end
                state_next = B_PF_WR;
            end
            B_PF_WR:
            begin
                acc_next = acc_sum;
                if (i_reg == LAST)
                begin
                    fin_next   = 1'b1;
                    state_next = B_IDLE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = B_PF_RD;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            it_reg    <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            it_reg    <= it_next;
            fin_reg   <= fin_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        p_even_reg <= p_even_next;
        inv_reg    <= inv_next;
        t_reg      <= t_next;
        hold_reg   <= hold_next;
        q_reg      <= q_next;
        sq_reg     <= sq_next;
        acc_reg    <= acc_next;
    end

    // Prefix write port
    assign pf_we    = (state_reg == B_PF_WR);
    assign pf_waddr = i_reg[IDX_W-1:0];
    assign pf_wdata = acc_sum;
    assign fin      = fin_reg;

endmodule

`default_nettype wire

// ----- src/totient_square_range_sum_core.sv -----
// ============================================================================
// totient_square_range_sum_core
// Sum of squared Euler totients over a range, served from prefix tables
// built on chip by a totient sieve.
// ============================================================================
// A build transfer (action 0) fills the tables and returns sum 0, status ok.
// It keeps busy high through the init pass, the prime test, the sieve over
// every multiple of each prime, the inverse setup for each odd prime and
// the prefix pass. The phi memory has one write port and one read port.
// A query transfer (action 1) returns its result through the prefix read
// registers and then the result register: both prefix entries are read in
// the same cycle from a two-read-port memory. A query that fails the
// ready or range check returns on the next cycle. Each result shows on
// done for exactly one cycle and must be captured then.
`timescale 1ns / 1ps
`default_nettype none

module totient_square_range_sum_core #(
    parameter int MAX_N = 65536
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               action,
    input  wire logic [tsrs_pkg::RANGE_W-1:0]       range_low,
    input  wire logic [tsrs_pkg::RANGE_W-1:0]       range_high,
    output logic                                    done,
    output logic [tsrs_pkg::SUM_W-1:0]              range_sum,
    output logic [tsrs_pkg::STATUS_W-1:0]           status
);

    localparam int IDX_W = $clog2(MAX_N + 1);
    localparam int CMP_W = (IDX_W + 1 > tsrs_pkg::RANGE_W) ? IDX_W + 1 : tsrs_pkg::RANGE_W;

    typedef enum logic [2:0] {
        T_IDLE  = 3'b001,
        T_QUERY = 3'b010,
        T_BUILD = 3'b100
    } tstate_t;

    tstate_t state_reg, state_next;
    logic    ready_reg, ready_next;
    logic    done_reg, done_next;
    logic [tsrs_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [tsrs_pkg::STATUS_W-1:0] status_reg, status_next;

    logic accept;
    logic go;
    logic fin;
    logic pf_we;
    logic [IDX_W-1:0] pf_waddr;
    logic [tsrs_pkg::SUM_W-1:0] pf_wdata;

    // Range decode
    logic [CMP_W-1:0] lo_ext, hi_ext, lo_m1;
    logic             bad_range;

    assign lo_ext    = CMP_W'(range_low);
    assign hi_ext    = CMP_W'(range_high);
    assign lo_m1     = lo_ext - 1'b1;
    assign bad_range = (lo_ext == '0) || (hi_ext > CMP_W'(MAX_N)) || (lo_ext > hi_ext);

    // Prefix memory: one write port, two read ports
    logic [tsrs_pkg::SUM_W-1:0] prefix_mem [0:MAX_N];
    logic [tsrs_pkg::SUM_W-1:0] rd_hi_reg, rd_lo_reg;

    always_ff @(posedge clk)
    begin
        if (pf_we)
        begin
            prefix_mem[pf_waddr] <= pf_wdata;
        end
        rd_hi_reg <= prefix_mem[hi_ext[IDX_W-1:0]];
        rd_lo_reg <= prefix_mem[lo_m1[IDX_W-1:0]];
    end

    // Table builder
    tsrs_builder #(
        .MAX_N (MAX_N)
    ) u_builder (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .fin      (fin),
        .pf_we    (pf_we),
        .pf_waddr (pf_waddr),
        .pf_wdata (pf_wdata)
    );

    assign busy   = (state_reg != T_IDLE);
    assign accept = start && !busy;

    // Command control
    always_comb
    begin
        state_next  = state_reg;
        ready_next  = ready_reg;
        done_next   = 1'b0;
        sum_next    = sum_reg;
        status_next = status_reg;
        go          = 1'b0;
        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    if (action == tsrs_pkg::ACT_BUILD)
                    begin
                        go         = 1'b1;
                        state_next = T_BUILD;
                    end
                    else if (!ready_reg)
                    begin
                        done_next   = 1'b1;
                        sum_next    = '0;
                        status_next = tsrs_pkg::ST_NOT_READY;
                    end
                    else if (bad_range)
                    begin
                        done_next   = 1'b1;
                        sum_next    = '0;
                        status_next = tsrs_pkg::ST_BAD_RANGE;
                    end
                    else
                    begin
                        state_next = T_QUERY;
                    end
                end
            end
            T_QUERY:
            begin
                done_next   = 1'b1;
                sum_next    = rd_hi_reg - rd_lo_reg;
                status_next = tsrs_pkg::ST_OK;
                state_next  = T_IDLE;
            end
            T_BUILD:
            begin
                if (fin)
                begin
                    done_next   = 1'b1;
                    sum_next    = '0;
                    status_next = tsrs_pkg::ST_OK;
                    ready_next  = 1'b1;
                    state_next  = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            ready_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            done_reg  <= done_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        status_reg <= status_next;
    end

    assign done      = done_reg;
    assign range_sum = sum_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

// ----- src/tsrs_checker.sv -----
// ============================================================================
// tsrs_checker
// Port-level checks of the totient square range-sum core, bound to the top.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tsrs_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic                              action,
    input wire logic [tsrs_pkg::RANGE_W-1:0]      range_low,
    input wire logic [tsrs_pkg::RANGE_W-1:0]      range_high,
    input wire logic                              done,
    input wire logic [tsrs_pkg::SUM_W-1:0]        range_sum,
    input wire logic [tsrs_pkg::STATUS_W-1:0]     status
);

    // Every transfer either starts work or answers on the next cycle
    a_transfer_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("transfer neither started work nor returned a result");

    // A build transfer raises busy in the cycle after it is taken
    a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == tsrs_pkg::ACT_BUILD) |=> busy)
        else $error("build transfer did not raise busy");

    // A query with a zero low bound fails at once
    a_zero_low_fails: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == tsrs_pkg::ACT_QUERY && range_low == '0)
        |=> (done && status != tsrs_pkg::ST_OK))
        else $error("query with zero low bound not rejected");

    // Failed queries carry a zero sum
    a_error_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != tsrs_pkg::ST_OK) |-> (range_sum == '0))
        else $error("error result with nonzero sum");

    // Results are shown only once the work is over
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

endmodule

bind totient_square_range_sum_core tsrs_checker u_tsrs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .range_low  (range_low),
    .range_high (range_high),
    .done       (done),
    .range_sum  (range_sum),
    .status     (status)
);

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for totient_square_range_sum_core. A short table of
// directed commands covers queries before any build, both builds, empty and
// inverted ranges and the table ends. About nine hundred random queries
// follow, mostly valid, the rest random or malformed. Every result is
// checked against its pinned answer or a totient sieve prefix-sum model.
// ============================================================================

module tb_top;

    localparam int TB_N         = 65536;
    localparam int RAND_QUERIES = 880;

    typedef struct packed {
        logic                         act;
        logic [tsrs_pkg::RANGE_W-1:0] lo;
        logic [tsrs_pkg::RANGE_W-1:0] hi;
    } cmd_t;

    typedef struct packed {
        logic [tsrs_pkg::SUM_W-1:0]    sum;
        logic [tsrs_pkg::STATUS_W-1:0] st;
    } answer_t;

    typedef struct packed {
        cmd_t    cmd;
        logic    pinned;
        answer_t ans;
    } step_t;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic                          action;
    logic [tsrs_pkg::RANGE_W-1:0]  range_low;
    logic [tsrs_pkg::RANGE_W-1:0]  range_high;
    logic                          done;
    logic [tsrs_pkg::SUM_W-1:0]    range_sum;
    logic [tsrs_pkg::STATUS_W-1:0] status;

    // Predictor state: totients, prefix sums of their squares, built flag
    bit [31:0] phi_ref   [0:TB_N];
    bit [63:0] sq_prefix [0:TB_N];
    bit        model_built;

    answer_t   expected_sums [$];
    step_t     directed [$];
    int        mismatches;
    int        burst_left;

    totient_square_range_sum_core #(
        .MAX_N(TB_N)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .range_low (range_low),
        .range_high(range_high),
        .done      (done),
        .range_sum (range_sum),
        .status    (status)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop well past the slowest correct run
    initial
    begin
        #300_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Expected result of one command; a build refills the predictor tables
    function automatic answer_t model_range_sum(input cmd_t c);
        answer_t   a;
        int        i;
        int        j;
        bit [63:0] t;
        a.sum = '0;
        a.st  = tsrs_pkg::ST_OK;
        if (c.act == tsrs_pkg::ACT_BUILD)
        begin
            phi_ref[0] = 0;
            phi_ref[1] = 1;
            for (i = 2; i <= TB_N; i++)
                phi_ref[i] = i;
            // an untouched entry marks a prime
            for (i = 2; i <= TB_N; i++)
                if (phi_ref[i] == i)
                    for (j = i; j <= TB_N; j += i)
                        phi_ref[j] -= phi_ref[j] / i;
            // phi(1) squared counts as zero
            sq_prefix[0] = 0;
            sq_prefix[1] = 0;
            for (i = 2; i <= TB_N; i++)
            begin
                t = phi_ref[i];
                sq_prefix[i] = sq_prefix[i-1] + t * t;
            end
            model_built = 1'b1;
        end
        else if (!model_built)
            a.st = tsrs_pkg::ST_NOT_READY;
        else if (c.lo < 1 || c.hi > TB_N || c.lo > c.hi)
            a.st = tsrs_pkg::ST_BAD_RANGE;
        else
            a.sum = sq_prefix[c.hi] - sq_prefix[c.lo - 1];
        return a;
    endfunction

    task automatic add_row(input logic act, input int lo, input int hi,
                           input logic pinned, input logic [tsrs_pkg::SUM_W-1:0] sum,
                           input logic [tsrs_pkg::STATUS_W-1:0] st);
        step_t s;
        s.cmd.act = act;
        s.cmd.lo  = lo[tsrs_pkg::RANGE_W-1:0];
        s.cmd.hi  = hi[tsrs_pkg::RANGE_W-1:0];
        s.pinned  = pinned;
        s.ans.sum = sum;
        s.ans.st  = st;
        directed  = {directed, s};
    endtask

    // Mostly valid ranges (short and long spans), the rest random or malformed
    function automatic cmd_t random_query();
        cmd_t c;
        int   lo;
        int   hi;
        int   pick;
        c.act = tsrs_pkg::ACT_QUERY;
        pick  = $urandom_range(0, 99);
        if (pick < 45)
        begin
            lo = $urandom_range(1, TB_N);
            hi = lo + $urandom_range(0, 40);
            if (hi > TB_N)
                hi = TB_N;
        end
        else if (pick < 75)
        begin
            lo = $urandom_range(1, TB_N);
            hi = $urandom_range(lo, TB_N);
        end
        else if (pick < 85)
        begin
            lo = $urandom;
            hi = $urandom;
        end
        else if (pick < 90)
        begin
            lo = 0;
            hi = $urandom_range(0, TB_N);
        end
        else if (pick < 95)
        begin
            lo = $urandom_range(1, TB_N);
            hi = $urandom_range(TB_N + 1, (1 << tsrs_pkg::RANGE_W) - 1);
        end
        else
        begin
            hi = $urandom_range(1, TB_N - 1);
            lo = $urandom_range(hi + 1, TB_N);
        end
        c.lo = lo[tsrs_pkg::RANGE_W-1:0];
        c.hi = hi[tsrs_pkg::RANGE_W-1:0];
        return c;
    endfunction

    // Drive one command, wait for its transfer, then pace the next one
    task automatic issue(input cmd_t c, input logic pinned, input answer_t pin);
        answer_t     a;
        int unsigned gap;
        action     <= c.act;
        range_low  <= c.lo;
        range_high <= c.hi;
        start      <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        a = model_range_sum(c);
        if (pinned)
            a = pin;
        expected_sums = {expected_sums, a};
        // bursts of back-to-back commands with random gaps between them
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 10);
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 30)
                                              : $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
    endtask

    // Result check: the receiver takes every strobe
    always @(posedge clk)
    begin : result_check
        answer_t want;
        if (rst_n === 1'b1 && done !== 1'b0)
        begin
            if (expected_sums.size() == 0)
                flag_mismatch($sformatf("result with nothing pending: sum %h status %0d",
                                        range_sum, status));
            else
            begin
                want = expected_sums.pop_front();
                if (range_sum !== want.sum)
                    flag_mismatch($sformatf("range_sum %h, expected %h",
                                            range_sum, want.sum));
                if (status !== want.st)
                    flag_mismatch($sformatf("status %0d, expected %0d",
                                            status, want.st));
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        step_t s;
        int    k;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        action     <= tsrs_pkg::ACT_BUILD;
        range_low  <= '0;
        range_high <= '0;
        mismatches  = 0;
        burst_left  = 0;

        // queries before any build: ready check comes before range check
        add_row(tsrs_pkg::ACT_QUERY, 1, 10, 1'b1, 64'd0, tsrs_pkg::ST_NOT_READY);
        add_row(tsrs_pkg::ACT_QUERY, 0, 0, 1'b1, 64'd0, tsrs_pkg::ST_NOT_READY);
        add_row(tsrs_pkg::ACT_QUERY, 131071, 131071, 1'b1, 64'd0, tsrs_pkg::ST_NOT_READY);
        // build ignores its range fields
        add_row(tsrs_pkg::ACT_BUILD, 131071, 131071, 1'b1, 64'd0, tsrs_pkg::ST_OK);
        add_row(tsrs_pkg::ACT_QUERY, 1, 1, 1'b1, 64'd0, tsrs_pkg::ST_OK);
        add_row(tsrs_pkg::ACT_QUERY, 2, 2, 1'b1, 64'd1, tsrs_pkg::ST_OK);
        add_row(tsrs_pkg::ACT_QUERY, 1, 3, 1'b1, 64'd5, tsrs_pkg::ST_OK);
        add_row(tsrs_pkg::ACT_QUERY, 100, 100, 1'b1, 64'd1600, tsrs_pkg::ST_OK);
        add_row(tsrs_pkg::ACT_QUERY, TB_N, TB_N, 1'b1, 64'd1073741824, tsrs_pkg::ST_OK);
        add_row(tsrs_pkg::ACT_QUERY, 0, 5, 1'b1, 64'd0, tsrs_pkg::ST_BAD_RANGE);
        add_row(tsrs_pkg::ACT_QUERY, 3, 2, 1'b1, 64'd0, tsrs_pkg::ST_BAD_RANGE);
        add_row(tsrs_pkg::ACT_QUERY, 1, TB_N + 1, 1'b1, 64'd0, tsrs_pkg::ST_BAD_RANGE);
        add_row(tsrs_pkg::ACT_QUERY, 131071, 131071, 1'b1, 64'd0, tsrs_pkg::ST_BAD_RANGE);
        add_row(tsrs_pkg::ACT_QUERY, TB_N, 1, 1'b1, 64'd0, tsrs_pkg::ST_BAD_RANGE);
        add_row(tsrs_pkg::ACT_QUERY, 0, 0, 1'b1, 64'd0, tsrs_pkg::ST_BAD_RANGE);
        add_row(tsrs_pkg::ACT_QUERY, TB_N + 1, TB_N + 1, 1'b1, 64'd0,
                tsrs_pkg::ST_BAD_RANGE);
        add_row(tsrs_pkg::ACT_QUERY, 1, TB_N, 1'b0, 64'd0, tsrs_pkg::ST_OK);
        add_row(tsrs_pkg::ACT_QUERY, TB_N - 1, TB_N, 1'b0, 64'd0, tsrs_pkg::ST_OK);
        add_row(tsrs_pkg::ACT_QUERY, 2, TB_N, 1'b0, 64'd0, tsrs_pkg::ST_OK);
        add_row(tsrs_pkg::ACT_QUERY, 21845, 43690, 1'b0, 64'd0, tsrs_pkg::ST_OK);
        // repeated build must leave the same tables
        add_row(tsrs_pkg::ACT_BUILD, 0, 0, 1'b1, 64'd0, tsrs_pkg::ST_OK);
        add_row(tsrs_pkg::ACT_QUERY, 1, TB_N, 1'b0, 64'd0, tsrs_pkg::ST_OK);
        add_row(tsrs_pkg::ACT_QUERY, 43690, 65535, 1'b0, 64'd0, tsrs_pkg::ST_OK);

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[k])
        begin
            s = directed[k];
            issue(s.cmd, s.pinned, s.ans);
        end

        for (k = 0; k < RAND_QUERIES; k++)
            issue(random_query(), 1'b0, '0);
        start <= 1'b0;

        // drain, then give stray results time to show
        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
